FILE: hdl/swdc_pkg.sv
package swdc_pkg;

  // Depth of the sliding window, in records.
  localparam int WINDOW = 50;

  localparam int RAW_W  = 16;
  localparam int COMP_W = 7;
  localparam int KEY_W  = 4 * COMP_W;

  // Division by 1000 as a multiply by a rounded-up reciprocal. The result
  // is exact for every magnitude up to 2**16.
  localparam int QUANT_MUL   = 67109;
  localparam int QUANT_SHIFT = 26;
  localparam int MUL_W       = 17;
  localparam int PROD_W      = RAW_W + MUL_W;
  localparam int QUOT_W      = 6;

  localparam int CNT_W     = $clog2(WINDOW + 1);
  localparam int OUT_W     = 6;
  localparam int COUNT_MAX = 63;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [OUT_W-1:0]  count_t;

endpackage

FILE: hdl/swdc_front.sv
module swdc_front
  import swdc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [4*RAW_W-1:0]      in_raw_i,
  output logic                    key_valid_o,
  input  logic                    key_ready_i,
  output key_t                    key_o
);

  // Stage one holds the raw components, stage two the registered quotients.
  logic                    s1_valid_q;
  logic [4*RAW_W-1:0]      s1_raw_q;
  logic                    s2_valid_q;
  logic [3:0][QUOT_W-1:0]  s2_quot_q;
  logic [3:0]              s2_neg_q;

  logic                    s1_ready;
  logic                    s2_ready;
  logic [3:0][QUOT_W-1:0]  quot_d;
  logic [3:0]              neg_d;

  assign s2_ready   = !s2_valid_q || key_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_comb begin
    logic [RAW_W-1:0]  raw;
    logic [RAW_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    for (int c = 0; c < 4; c++) begin
      raw       = s1_raw_q[c*RAW_W +: RAW_W];
      mag       = raw[RAW_W-1] ? (~raw + RAW_W'(1)) : raw;
      prod      = PROD_W'(mag) * PROD_W'(QUANT_MUL);
      quot_d[c] = prod[QUANT_SHIFT +: QUOT_W];
      neg_d[c]  = raw[RAW_W-1];
    end
  end

  always_comb begin
    logic [COMP_W-1:0] q;
    for (int c = 0; c < 4; c++) begin
      q = COMP_W'(s2_quot_q[c]);
      // Component w lands in the top bits, z in the lowest.
      key_o[(3-c)*COMP_W +: COMP_W] = s2_neg_q[c] ? (~q + COMP_W'(1)) : q;
    end
  end

  assign key_valid_o = s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_raw_q <= in_raw_i;
    end
    if (s2_ready && s1_valid_q) begin
      s2_quot_q <= quot_d;
      s2_neg_q  <= neg_d;
    end
  end

endmodule

FILE: hdl/swdc_queue.sv
module swdc_queue
  import swdc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  key_t  push_key_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output key_t  pop_key_o
);

  key_t                entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q;
  logic [QPTR_W-1:0]   rd_ptr_q;
  logic [QPTR_W:0]     level_q;
  logic                push;
  logic                pop;

  assign push_ready_o = level_q != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid_o  = level_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_key_o    = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        level_q <= level_q + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        level_q <= level_q - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_key_i;
    end
  end

endmodule

FILE: hdl/swdc_back.sv
module swdc_back
  import swdc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    key_valid_i,
  output logic    key_ready_o,
  input  key_t    key_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output count_t  out_count_o
);

  // Shift line: entry 0 is the newest key, entry WINDOW-1 the oldest.
  key_t              win_q [WINDOW];
  logic [CNT_W-1:0]  fill_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  cnt_d;
  logic              out_valid_q;
  count_t            out_count_q;

  logic              step;
  logic              full;
  logic              new_dup;
  logic              evict_dup;

  assign key_ready_o = !out_valid_q || out_ready_i;
  assign step        = key_valid_i && key_ready_o;
  assign full        = fill_q == CNT_W'(WINDOW);

  // Only entries that survive this step are compared: when full, the
  // oldest one leaves; otherwise every valid entry stays.
  always_comb begin
    new_dup   = 1'b0;
    evict_dup = 1'b0;
    for (int i = 0; i < WINDOW - 1; i++) begin
      if ((CNT_W'(i) < fill_q) && (win_q[i] == key_i)) begin
        new_dup = 1'b1;
      end
      if (win_q[i] == win_q[WINDOW-1]) begin
        evict_dup = 1'b1;
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (!new_dup) begin
      cnt_d = cnt_d + CNT_W'(1);
    end
    if (full && !evict_dup) begin
      cnt_d = cnt_d - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        cnt_q <= cnt_d;
        if (!full) begin
          fill_q <= fill_q + CNT_W'(1);
        end
      end
      if (key_ready_o) begin
        out_valid_q <= key_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      win_q[0] <= key_i;
      for (int i = 1; i < WINDOW; i++) begin
        win_q[i] <= win_q[i-1];
      end
      if (int'(cnt_d) > COUNT_MAX) begin
        out_count_q <= OUT_W'(COUNT_MAX);
      end else begin
        out_count_q <= OUT_W'(cnt_d);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_count_o = out_count_q;

endmodule

FILE: hdl/sliding_window_distinct_count_top.sv
// Path: a record beat passes through the front-end stages and the queue, and its result
// is registered in the back end's output register. Throughput: one record beat per cycle
// unless results stall; the back end's compare and count update are combinational.
// Reset (rst_ni, asynchronous, active low) empties the pipeline and queue and clears the
// fill level and distinct count; window contents are left as they are and never read
// before being written.
module sliding_window_distinct_count_top
  import swdc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // Fields from bit 0 up: comp_w [15:0], comp_x [31:16], comp_y [47:32], comp_z [63:48].
  input  logic [63:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // Fields from bit 0 up: distinct_count [5:0], zero fill [7:6].
  output logic [7:0]   m_axis_tdata_o
);

  // The front end registers each record beat and quantizes its four
  // components into a 28-bit key over two stages.
  logic    fe_valid;
  logic    fe_ready;
  key_t    fe_key;

  // The four-entry queue lets the front end keep accepting beats while
  // the result side is stalled, until the queue fills.
  logic    q_valid;
  logic    q_ready;
  key_t    q_key;
  count_t  be_count;

  swdc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_raw_i    (s_axis_tdata_i),
    .key_valid_o (fe_valid),
    .key_ready_i (fe_ready),
    .key_o       (fe_key)
  );

  swdc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_key_i   (fe_key),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_key_o    (q_key)
  );

  // The back end holds the window as a shift line and keeps the distinct
  // count up to date: a new key adds one unless it already sits in the
  // surviving entries, and the evicted key takes one away unless a copy of
  // it survives. The result sits in an output register so the next key
  // can be taken in the same cycle the current result leaves.
  swdc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_valid_i (q_valid),
    .key_ready_o (q_ready),
    .key_i       (q_key),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_count_o (be_count)
  );

  assign m_axis_tdata_o = {2'b00, be_count};

endmodule

FILE: hdl/swdc_checker.sv
module swdc_sva
  import swdc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_o,
  input  logic [63:0]  s_axis_tdata_i,
  input  logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  input  logic [7:0]   m_axis_tdata_o
);

  logic        in_beat;
  logic        out_beat;
  logic [3:0]  pending_q;
  logic [8:0]  seen_q;

  assign in_beat  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_beat = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      seen_q    <= '0;
    end else begin
      pending_q <= pending_q + 4'(in_beat) - 4'(out_beat);
      if (in_beat && seen_q != 9'h1ff) begin
        seen_q <= seen_q + 9'd1;
      end
    end
  end

  a_no_orphan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> pending_q != 4'd0)
    else $error("result beat without an outstanding record beat");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[7:6] == 2'b00 && m_axis_tdata_o[5:0] != 6'd0
                        && 9'(m_axis_tdata_o[5:0]) <= seen_q)
    else $error("distinct count outside the possible range");

  a_count_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (WINDOW > COUNT_MAX) || (int'(m_axis_tdata_o[5:0]) <= WINDOW))
    else $error("distinct count exceeds the window depth");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result beat changed");

endmodule

bind sliding_window_distinct_count_top swdc_sva u_swdc_sva (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

FILE: bench/swdc_checker.sv
// Watches both stream channels of the distinct-count block. Every accepted
// record beat updates a private copy of the sliding window and queues the
// count the block should report for it. Every accepted result beat is then
// compared against the oldest queued count.
module swdc_checker
  import swdc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rec_tvalid_i,
  input  logic        rec_tready_i,
  input  logic [63:0] rec_tdata_i,
  input  logic        cnt_tvalid_i,
  input  logic        cnt_tready_i,
  input  logic [7:0]  cnt_tdata_i,
  output int          fail_count_o,
  output int          pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUANT_DIV = 1000;

  key_t   window_keys [WINDOW];
  int     fill_level;
  int     oldest_slot;
  count_t expected_counts [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    fill_level   = 0;
    oldest_slot  = 0;
  end

  task report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    fail_count_o++;
  endtask

  // Division of signed ints truncates toward zero, as the block requires.
  function automatic logic [COMP_W-1:0] quantize_comp(input logic signed [RAW_W-1:0] raw);
    int q;
    q = int'(raw) / QUANT_DIV;
    return q[COMP_W-1:0];
  endfunction

  function automatic key_t record_key(input logic [63:0] rec);
    return {quantize_comp(rec[15:0]), quantize_comp(rec[31:16]),
            quantize_comp(rec[47:32]), quantize_comp(rec[63:48])};
  endfunction

  function automatic count_t window_distinct();
    int  n;
    bit  seen;
    n = 0;
    for (int i = 0; i < fill_level; i++) begin
      seen = 0;
      for (int j = 0; j < i; j++) begin
        if (window_keys[(oldest_slot + j) % WINDOW] == window_keys[(oldest_slot + i) % WINDOW])
          seen = 1;
      end
      if (!seen) n++;
    end
    if (n > COUNT_MAX) n = COUNT_MAX;
    return count_t'(n);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    count_t want;
    if (!rst_ni) begin
      fill_level  = 0;
      oldest_slot = 0;
      expected_counts.delete();
    end else begin
      if (rec_tvalid_i && rec_tready_i) begin
        if (fill_level < WINDOW) begin
          window_keys[(oldest_slot + fill_level) % WINDOW] = record_key(rec_tdata_i);
          fill_level++;
        end else begin
          window_keys[oldest_slot] = record_key(rec_tdata_i);
          oldest_slot = (oldest_slot + 1) % WINDOW;
        end
        expected_counts.push_back(window_distinct());
      end
      if (cnt_tvalid_i && cnt_tready_i) begin
        if (expected_counts.size() == 0) begin
          report_mismatch($sformatf("result beat 0x%02h with no record waiting", cnt_tdata_i));
        end else begin
          want = expected_counts.pop_front();
          if (cnt_tdata_i[OUT_W-1:0] !== want)
            report_mismatch($sformatf("distinct_count got %0d, expected %0d",
                                      cnt_tdata_i[OUT_W-1:0], want));
        end
        if (cnt_tdata_i[7:OUT_W] !== '0)
          report_mismatch($sformatf("fill bits of result beat not zero: 0x%02h", cnt_tdata_i));
      end
    end
    pending_o = expected_counts.size();
  end

endmodule

FILE: bench/sliding_window_distinct_count_top_tb.sv
// Top of the distinct-count bench. It drives record beats, throttles the
// result side, and gives the verdict; all prediction and comparison live in
// the checker instantiated next to the block.
module sliding_window_distinct_count_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import swdc_pkg::*;

  // Cycles without any accepted beat before the run is declared hung. The
  // longest source gap and sink stall, both drawn by pick_gap, stay far below it.
  localparam int IDLE_LIMIT   = 2000;
  // Cycles waited after the last result, well above the block's latency.
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS  = 200;
  localparam int NUM_PHASES   = 6;

  // Raw values around the quantizer's boundaries and the field extremes.
  localparam int EDGE_VALS [16] = '{0, -1, 1, 999, -999, 1000, -1000, 1001,
                                    -1001, 1999, -1999, 32000, -32000, 32767,
                                    -32768, 31999};

  // Magnitude of the quantized values used per random phase; a negative
  // span means fully random raw components.
  localparam int PHASE_SPAN [NUM_PHASES] = '{0, 1, 2, 5, 32, -1};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;

  // While calm is set, neither side idles, giving back-to-back stretches.
  bit          calm = 1'b0;
  int          fail_count;
  int          pending;

  always #10 clk_i = ~clk_i;

  sliding_window_distinct_count_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  swdc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rec_tvalid_i (s_axis_tvalid_i),
    .rec_tready_i (s_axis_tready_o),
    .rec_tdata_i  (s_axis_tdata_i),
    .cnt_tvalid_i (m_axis_tvalid_o),
    .cnt_tready_i (m_axis_tready_i),
    .cnt_tdata_i  (m_axis_tdata_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] pack_rec(input int w, input int x, input int y, input int z);
    logic [15:0] fw, fx, fy, fz;
    fw = w[15:0];
    fx = x[15:0];
    fy = y[15:0];
    fz = z[15:0];
    return {fz, fy, fx, fw};
  endfunction

  // Picks a quantized value in -span..span and then a raw value that
  // truncates to it, so that keys collide often and the distinct count
  // moves across its whole range. One component in ten is pure noise.
  function automatic int make_comp(input int span);
    int q, raw;
    if (span < 0 || $urandom_range(0, 9) == 0) begin
      raw = $urandom_range(0, 65535);
      return raw - 32768;
    end
    q = int'($urandom_range(0, 2 * span)) - span;
    if (q > 0)
      raw = q * 1000 + int'($urandom_range(0, 999));
    else if (q < 0)
      raw = q * 1000 - int'($urandom_range(0, 999));
    else
      raw = int'($urandom_range(0, 1998)) - 999;
    if (raw > 32767) raw = 32767;
    if (raw < -32768) raw = -32768;
    return raw;
  endfunction

  // Offers one record beat and returns just after the edge that took it.
  // A valid that stays high into the next beat is never lowered in between.
  task send_record(input logic [63:0] rec);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= rec;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Result side back-pressure: ready drops now and then for a random stretch.
  initial begin : sink_stall
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (!calm && rst_ni && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        hold = pick_gap();
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Watchdog: a run of cycles with no beat accepted on either side means
  // the block has hung.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Watchdog expired after %0d idle cycles", IDLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The window starts empty, so the first records also
    // exercise the fill ramp. Values that truncate to zero (999, -1, -999)
    // must land on the same key as zero, and the extremes -32768 and 32767
    // must quantize to -32 and 32.
    send_record(pack_rec(0, 0, 0, 0));
    send_record(pack_rec(999, -999, -1, 1));
    send_record(pack_rec(-32768, -32768, -32768, -32768));
    send_record(pack_rec(32767, 32767, 32767, 32767));
    send_record(pack_rec(32000, 32000, 32000, 32000));
    send_record(pack_rec(-32000, -32000, -32000, -32000));
    for (int i = 0; i < 16; i++)
      send_record(pack_rec(EDGE_VALS[i], EDGE_VALS[(i + 3) % 16],
                           EDGE_VALS[(i + 7) % 16], EDGE_VALS[(i + 11) % 16]));
    // Keys differing in a single component must count as distinct.
    send_record(pack_rec(1000, 0, 0, 0));
    send_record(pack_rec(0, 0, 0, 1000));

    // Random phases, each with its own key spread. Every phase is longer
    // than the window, so the ring wraps many times over with the oldest
    // key dropping out each beat. One phase runs with no idling at all.
    for (int p = 0; p < NUM_PHASES; p++) begin
      calm = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_record(pack_rec(make_comp(PHASE_SPAN[p]), make_comp(PHASE_SPAN[p]),
                             make_comp(PHASE_SPAN[p]), make_comp(PHASE_SPAN[p])));
    end

    s_axis_tvalid_i <= 1'b0;
    calm = 1'b1;

    // The checker updates its queue at the rising edge, so look at it on
    // the falling edge. The watchdog covers results that never arrive.
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (pending != 0)
      $display("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/swdc_pkg.sv
hdl/swdc_front.sv
hdl/swdc_queue.sv
hdl/swdc_back.sv
hdl/sliding_window_distinct_count_top.sv
hdl/swdc_checker.sv
bench/swdc_checker.sv
bench/sliding_window_distinct_count_top_tb.sv
